@@ sv/sce_pkg.sv @@
// ----------------------------------------------------------------------------
// sce_pkg: shared types and constants of the sponge cipher block encrypt
// State word type, datapath commands, result kinds, register indexes and the
// permutation round function.
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

   localparam int WORD_W = 64;
   localparam int NWORDS = 5;
   localparam int CSR_IDX_W = 3;

   typedef logic [NWORDS-1:0][WORD_W-1:0] state_type;

   localparam logic [WORD_W-1:0] SCE_IV = 64'h80400c0600000000;

   localparam logic [3:0] RND_FIRST = 4'd0;
   localparam logic [3:0] RND_MSG   = 4'd6;
   localparam logic [3:0] RND_LAST  = 4'd11;

   localparam logic [1:0] KIND_CT   = 2'd0;
   localparam logic [1:0] KIND_TAG1 = 2'd1;
   localparam logic [1:0] KIND_TAG2 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_LOW  = 3'd3;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROUND,
      OP_ABSORB,
      OP_KEY12,
      OP_KEY34
   } op_type;

   typedef enum logic [1:0] {
      SEL_CT,
      SEL_W3,
      SEL_W4
   } out_sel_type;

   typedef struct packed {
      op_type      op;
      logic        use_port;
      logic        take_plain;
      logic [3:0]  rc_idx;
      logic        out_load;
      out_sel_type out_sel;
      logic [1:0]  out_kind;
      logic        out_run_end;
   } cmd_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   // one permutation round: constant add, 5-bit s-box, linear diffusion
   function automatic state_type sce_round(input state_type s_in, input logic [3:0] idx);
      state_type s;
      state_type t;
      s = s_in;
      s[2] = s[2] ^ {56'd0, ~idx, idx};
      s[0] = s[0] ^ s[4];
      s[4] = s[4] ^ s[3];
      s[2] = s[2] ^ s[1];
      t[0] = ~s[0] & s[1];
      t[1] = ~s[1] & s[2];
      t[2] = ~s[2] & s[3];
      t[3] = ~s[3] & s[4];
      t[4] = ~s[4] & s[0];
      s[0] = s[0] ^ t[1];
      s[1] = s[1] ^ t[2];
      s[2] = s[2] ^ t[3];
      s[3] = s[3] ^ t[4];
      s[4] = s[4] ^ t[0];
      s[1] = s[1] ^ s[0];
      s[0] = s[0] ^ s[4];
      s[3] = s[3] ^ s[2];
      s[2] = ~s[2];
      s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
      s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
      s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
      s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
      s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/sce_chan_if.sv @@
// ----------------------------------------------------------------------------
// sce_chan_if: request and response channels
// Valid/ready channels carrying a plaintext beat in and a result beat out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sce_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_word;
   logic        first_word;
   logic        final_word;

   modport source (output valid, plain_word, first_word, final_word, input ready);
   modport sink (input valid, plain_word, first_word, final_word, output ready);
endinterface

interface sce_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_word;
   logic [1:0]  word_kind;
   logic        run_end;

   modport source (output valid, out_word, word_kind, run_end, input ready);
   modport sink (input valid, out_word, word_kind, run_end, output ready);
endinterface

`default_nettype wire

@@ sv/sce_ctrl.sv @@
// ----------------------------------------------------------------------------
// sce_ctrl: sequencer of the sponge cipher
// Runs initialization, absorb, message rounds, finalization and tag output,
// issuing one datapath command per cycle and tracking the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_ctrl
   import sce_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  wire     req_first,
   input  wire     req_final,
   input  wire     rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_INIT_KEY,
      ST_ABSORB,
      ST_MSG,
      ST_KEY12,
      ST_FIN,
      ST_FIN_KEY,
      ST_TAG1,
      ST_TAG2
   } st_type;

   st_type     st_ff, st_in;
   logic [3:0] rnd_ff, rnd_in;
   logic       final_ff, final_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (st_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      st_in        = st_ff;
      rnd_in       = rnd_ff;
      final_in     = final_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd.op          = OP_NONE;
      cmd.use_port    = 1'b0;
      cmd.take_plain  = 1'b0;
      cmd.rc_idx      = rnd_ff;
      cmd.out_load    = 1'b0;
      cmd.out_sel     = SEL_CT;
      cmd.out_kind    = KIND_CT;
      cmd.out_run_end = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               final_in       = req_final;
               cmd.take_plain = 1'b1;
               if (req_first) begin
                  cmd.op = OP_LOAD;
                  st_in  = ST_INIT;
                  rnd_in = RND_FIRST;
               end else begin
                  cmd.op          = OP_ABSORB;
                  cmd.use_port    = 1'b1;
                  cmd.out_load    = 1'b1;
                  cmd.out_run_end = !req_final;
                  out_valid_in    = 1'b1;
                  st_in           = ST_MSG;
                  rnd_in          = RND_MSG;
               end
            end
         end
         ST_INIT: begin
            cmd.op = OP_ROUND;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == RND_LAST) begin
               st_in = ST_INIT_KEY;
            end
         end
         ST_INIT_KEY: begin
            cmd.op = OP_KEY34;
            st_in  = ST_ABSORB;
         end
         ST_ABSORB: begin
            if (out_free) begin
               cmd.op          = OP_ABSORB;
               cmd.out_load    = 1'b1;
               cmd.out_run_end = !final_ff;
               out_valid_in    = 1'b1;
               st_in           = ST_MSG;
               rnd_in          = RND_MSG;
            end
         end
         ST_MSG: begin
            cmd.op = OP_ROUND;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == RND_LAST) begin
               st_in = final_ff ? ST_KEY12 : ST_IDLE;
            end
         end
         ST_KEY12: begin
            cmd.op = OP_KEY12;
            st_in  = ST_FIN;
            rnd_in = RND_FIRST;
         end
         ST_FIN: begin
            cmd.op = OP_ROUND;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == RND_LAST) begin
               st_in = ST_FIN_KEY;
            end
         end
         ST_FIN_KEY: begin
            cmd.op = OP_KEY34;
            st_in  = ST_TAG1;
         end
         ST_TAG1: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_W3;
               cmd.out_kind = KIND_TAG1;
               out_valid_in = 1'b1;
               st_in        = ST_TAG2;
            end
         end
         ST_TAG2: begin
            if (out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_sel     = SEL_W4;
               cmd.out_kind    = KIND_TAG2;
               cmd.out_run_end = 1'b1;
               out_valid_in    = 1'b1;
               st_in           = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rnd_ff       <= RND_FIRST;
         final_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rnd_ff       <= rnd_in;
         final_ff     <= final_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten while a beat is pending");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ROUND) |-> (rnd_ff <= RND_LAST))
      else $error("round index out of range");

   a_tag2_follows: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_TAG1 && out_free) |=> (st_ff == ST_TAG2 && out_valid_ff))
      else $error("second tag beat not sequenced after the first");

   a_first_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && req_first) |=> (st_ff == ST_INIT && rnd_ff == RND_FIRST))
      else $error("initialization not started on a first beat");

endmodule

`default_nettype wire

@@ sv/sce_datapath.sv @@
// ----------------------------------------------------------------------------
// sce_datapath: sponge state, key/nonce registers and result register
// Executes one command per cycle: load, one round, absorb or key XOR.
// ----------------------------------------------------------------------------
`default_nettype none

module sce_datapath
   import sce_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  cmd_type               cmd,
   input  wire [WORD_W-1:0]      req_plain,
   input  wire                   csr_we,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [WORD_W-1:0]      csr_wdata,
   output logic [WORD_W-1:0]     rsp_word,
   output logic [1:0]            rsp_kind,
   output logic                  rsp_run_end
);

   state_type         sponge_ff, sponge_in;
   logic [WORD_W-1:0] key_high_ff, key_low_ff, nonce_high_ff, nonce_low_ff;
   logic [WORD_W-1:0] plain_ff;
   logic [WORD_W-1:0] plain_sel;
   logic [WORD_W-1:0] out_word_ff, out_word_in;
   logic [1:0]        out_kind_ff;
   logic              out_run_end_ff;

   assign plain_sel = cmd.use_port ? req_plain : plain_ff;

   always_comb begin
      sponge_in = sponge_ff;
      case (cmd.op)
         OP_LOAD: begin
            sponge_in[0] = SCE_IV;
            sponge_in[1] = key_high_ff;
            sponge_in[2] = key_low_ff;
            sponge_in[3] = nonce_high_ff;
            sponge_in[4] = nonce_low_ff;
         end
         OP_ROUND: begin
            sponge_in = sce_round(sponge_ff, cmd.rc_idx);
         end
         OP_ABSORB: begin
            sponge_in[0] = sponge_ff[0] ^ plain_sel;
         end
         OP_KEY12: begin
            sponge_in[1] = sponge_ff[1] ^ key_high_ff;
            sponge_in[2] = sponge_ff[2] ^ key_low_ff;
         end
         OP_KEY34: begin
            sponge_in[3] = sponge_ff[3] ^ key_high_ff;
            sponge_in[4] = sponge_ff[4] ^ key_low_ff;
         end
         default: begin
            sponge_in = sponge_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.out_sel)
         SEL_W3:  out_word_in = sponge_ff[3];
         SEL_W4:  out_word_in = sponge_ff[4];
         default: out_word_in = sponge_ff[0] ^ plain_sel;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sponge_ff     <= '0;
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         nonce_high_ff <= '0;
         nonce_low_ff  <= '0;
      end else begin
         sponge_ff <= sponge_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
               CSR_KEY_LOW:    key_low_ff    <= csr_wdata;
               CSR_NONCE_HIGH: nonce_high_ff <= csr_wdata;
               CSR_NONCE_LOW:  nonce_low_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_plain) begin
         plain_ff <= req_plain;
      end
      if (cmd.out_load) begin
         out_word_ff    <= out_word_in;
         out_kind_ff    <= cmd.out_kind;
         out_run_end_ff <= cmd.out_run_end;
      end
   end

   assign rsp_word    = out_word_ff;
   assign rsp_kind    = out_kind_ff;
   assign rsp_run_end = out_run_end_ff;

endmodule

`default_nettype wire

@@ sv/sponge_cipher_block_encrypt_top.sv @@
// A plain beat's ciphertext is registered at accept and is valid in the cycle after;
// a first beat first runs the initialization rounds and key XOR, a final beat then
// the finalization rounds, key XOR and tag beats; a new beat is accepted only when idle.
// One permutation round per cycle through the single round unit.
// Reset: synchronous, active high; clears sponge state, key/nonce and control.
// ----------------------------------------------------------------------------
// sponge_cipher_block_encrypt_top: sponge cipher encryption engine
// Absorbs 64-bit plaintext beats, returns ciphertext beats and a two-beat tag.
// ----------------------------------------------------------------------------
`default_nettype none

module sponge_cipher_block_encrypt_top
   import sce_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   sce_req_if.sink             req_chan,
   sce_rsp_if.source           rsp_chan,
   input  wire                 csr_we,
   input  wire [CSR_IDX_W-1:0] csr_index,
   input  wire [WORD_W-1:0]    csr_wdata
);

   cmd_type cmd;

   sce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_first (req_chan.first_word),
      .req_final (req_chan.final_word),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   sce_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_plain   (req_chan.plain_word),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_word    (rsp_chan.out_word),
      .rsp_kind    (rsp_chan.word_kind),
      .rsp_run_end (rsp_chan.run_end)
   );

endmodule

`default_nettype wire
